// ===== sv/enfa_pkg.sv =====
// Shared types and constants for the epsilon-NFA acceptor.
package enfa_pkg;

  localparam int NUM_STATES_DEF = 16;
  localparam int MAX_EDGES_DEF  = 64;

  localparam int STATE_W   = 4;
  localparam int SET_W     = 16;
  localparam int LABEL_W   = 8;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_BEGIN = 2'd2,
    OP_FEED  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PRESENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK    = 2'd2;

  typedef struct packed {
    logic [STATE_W-1:0] src;
    logic [STATE_W-1:0] dst;
    logic               eps;
    logic [LABEL_W-1:0] label;
  } edge_t;

endpackage

// ===== sv/epsilon_nfa_acceptor.sv =====
// Epsilon-NFA acceptor: edge table, set simulation sequencer and result register.
//
// The block holds up to MAX_EDGES automaton edges in a table with one write
// and one read port and simulates the automaton on a bit set of active states.
// Clear and add-edge items go from idle straight to the result state. A
// begin-string item runs epsilon-closure passes over the table; a feed-symbol
// item runs one move pass and then closure passes. Every pass walks the stored
// edges one per cycle through one shared edge matcher. Closure passes repeat
// until a pass adds nothing, so their number is at most one more than the
// number of states the closure adds. The table read port is the limit: one
// edge per cycle. While an item is being worked on, in_stall is high. A
// finished result sits in the output register until it is transferred, and
// the block keeps taking the next item meanwhile. Configuration writes are
// accepted at any time but must only be issued while the block is idle.
module epsilon_nfa_acceptor #(
  parameter int NUM_STATES = enfa_pkg::NUM_STATES_DEF,
  parameter int MAX_EDGES  = enfa_pkg::MAX_EDGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [enfa_pkg::OP_W-1:0]        in_operation,
  input  logic [enfa_pkg::STATE_W-1:0]     in_edge_source,
  input  logic [enfa_pkg::STATE_W-1:0]     in_edge_dest,
  input  logic                             in_edge_epsilon,
  input  logic [enfa_pkg::LABEL_W-1:0]     in_symbol,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_accepted,
  output logic [enfa_pkg::SET_W-1:0]       out_active_states,
  output logic                             out_table_full,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [enfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [enfa_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import enfa_pkg::*;

  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int AW = $clog2(MAX_EDGES);
  // states at or above NUM_STATES do not exist
  localparam logic [SET_W-1:0] LIVE_MASK = (NUM_STATES >= SET_W) ? {SET_W{1'b1}} :
                                           SET_W'((32'd1 << NUM_STATES) - 32'd1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_CLOSE,
    S_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       edge_count_r, edge_count_nxt;
  logic [SET_W-1:0]    active_r, active_nxt;
  logic [SET_W-1:0]    move_r, move_nxt;
  logic [CW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                grew_r, grew_nxt;
  logic                full_r, full_nxt;
  logic [LABEL_W-1:0]  sym_r, sym_nxt;
  logic [STATE_W-1:0]  start_index_r, start_index_nxt;
  logic                start_present_r, start_present_nxt;
  logic [SET_W-1:0]    final_mask_r, final_mask_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_accepted_r, out_accepted_nxt;
  logic [SET_W-1:0]    out_active_r, out_active_nxt;
  logic                out_full_r, out_full_nxt;

  // edge table
  edge_t               edge_mem [MAX_EDGES];
  edge_t               mem_q_r;
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  edge_t               mem_wr_data;
  logic                mem_rd_en;

  logic                in_xfer;
  logic                out_free;
  logic                pass_active;
  logic                pass_done;
  logic [SET_W-1:0]    dbit;
  logic [SET_W-1:0]    sbit;
  logic                src_on;
  logic                eps_hit;
  logic                sym_hit;
  op_t                 op;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign op        = op_t'(in_operation);

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_active_states = out_active_r;
  assign out_table_full    = out_full_r;

  // Shared edge matcher: one table entry per cycle against the active set.
  assign dbit    = (SET_W'(1) << mem_q_r.dst) & LIVE_MASK;
  assign sbit    = (SET_W'(1) << start_index_r) & LIVE_MASK;
  assign src_on  = active_r[mem_q_r.src];
  assign eps_hit = rd_vld_r && mem_q_r.eps && src_on && ((dbit & ~active_r) != '0);
  assign sym_hit = rd_vld_r && !mem_q_r.eps && (mem_q_r.label == sym_r) && src_on;

  assign pass_active = (state_r == S_MOVE) || (state_r == S_CLOSE);
  assign mem_rd_en   = pass_active && (rd_ptr_r < edge_count_r);
  // the pass ends once every edge was issued and the last read was consumed
  assign pass_done   = pass_active && (rd_ptr_r == edge_count_r) && !rd_vld_r;

  assign mem_wr_en   = in_xfer && (op == OP_ADD) && (edge_count_r < CW'(MAX_EDGES));
  assign mem_wr_addr = edge_count_r[AW-1:0];
  assign mem_wr_data = '{src: in_edge_source, dst: in_edge_dest,
                         eps: in_edge_epsilon, label: in_symbol};

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      edge_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      mem_q_r <= edge_mem[rd_ptr_r[AW-1:0]];
    end
  end

  always_comb begin
    state_nxt         = state_r;
    edge_count_nxt    = edge_count_r;
    active_nxt        = active_r;
    move_nxt          = move_r;
    rd_ptr_nxt        = rd_ptr_r;
    rd_vld_nxt        = mem_rd_en;
    grew_nxt          = grew_r;
    full_nxt          = full_r;
    sym_nxt           = sym_r;
    start_index_nxt   = start_index_r;
    start_present_nxt = start_present_r;
    final_mask_nxt    = final_mask_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_accepted_nxt  = out_accepted_r;
    out_active_nxt    = out_active_r;
    out_full_nxt      = out_full_r;

    if (mem_rd_en) begin
      rd_ptr_nxt = rd_ptr_r + CW'(1);
    end

    // configuration writes; indexes past the register list are dropped
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_INDEX:   start_index_nxt   = cfg_data[STATE_W-1:0];
        CFG_START_PRESENT: start_present_nxt = cfg_data[0];
        CFG_FINAL_MASK:    final_mask_nxt    = cfg_data[SET_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          full_nxt   = 1'b0;
          rd_ptr_nxt = '0;
          rd_vld_nxt = 1'b0;
          grew_nxt   = 1'b0;
          sym_nxt    = in_symbol;
          unique case (op)
            OP_CLEAR: begin
              edge_count_nxt = '0;
              state_nxt      = S_RESULT;
            end
            OP_ADD: begin
              // drop the edge and flag it when the table is full
              if (mem_wr_en) begin
                edge_count_nxt = edge_count_r + CW'(1);
              end else begin
                full_nxt = 1'b1;
              end
              state_nxt = S_RESULT;
            end
            OP_BEGIN: begin
              active_nxt = start_present_r ? sbit : '0;
              state_nxt  = S_CLOSE;
            end
            OP_FEED: begin
              move_nxt  = '0;
              state_nxt = S_MOVE;
            end
          endcase
        end
      end
      S_MOVE: begin
        if (sym_hit) begin
          move_nxt = move_r | dbit;
        end
        if (pass_done) begin
          active_nxt = move_r & LIVE_MASK;
          rd_ptr_nxt = '0;
          grew_nxt   = 1'b0;
          state_nxt  = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (eps_hit) begin
          active_nxt = active_r | dbit;
          grew_nxt   = 1'b1;
        end
        if (pass_done) begin
          // repeat the pass until the set stops growing
          rd_ptr_nxt = '0;
          grew_nxt   = 1'b0;
          state_nxt  = grew_r ? S_CLOSE : S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_accepted_nxt = start_present_r && ((active_r & final_mask_r & LIVE_MASK) != '0);
          out_active_nxt   = active_r;
          out_full_nxt     = full_r;
          state_nxt        = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      edge_count_r    <= '0;
      active_r        <= '0;
      rd_ptr_r        <= '0;
      rd_vld_r        <= 1'b0;
      grew_r          <= 1'b0;
      full_r          <= 1'b0;
      start_index_r   <= '0;
      start_present_r <= 1'b0;
      final_mask_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      edge_count_r    <= edge_count_nxt;
      active_r        <= active_nxt;
      rd_ptr_r        <= rd_ptr_nxt;
      rd_vld_r        <= rd_vld_nxt;
      grew_r          <= grew_nxt;
      full_r          <= full_nxt;
      start_index_r   <= start_index_nxt;
      start_present_r <= start_present_nxt;
      final_mask_r    <= final_mask_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    move_r         <= move_nxt;
    sym_r          <= sym_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_active_r   <= out_active_nxt;
    out_full_r     <= out_full_nxt;
  end

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_count_r <= CW'(MAX_EDGES))
    else $error("edge count exceeds table depth");

  // The active set never holds a state that does not exist.
  a_live_only: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r & ~LIVE_MASK) == '0)
    else $error("active set holds a nonexistent state");

  // Table reads are only in flight during a pass.
  a_read_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_MOVE || state_r == S_CLOSE))
    else $error("table read outside a pass");

  // Without a start state no result may accept.
  a_no_start_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !start_present_r) |-> !out_accepted_r)
    else $error("accept reported without a start state");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the epsilon-NFA acceptor: stimulus, set-simulation predictor, checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import enfa_pkg::*;

  localparam int NUM_STATES = NUM_STATES_DEF;
  localparam int MAX_EDGES  = MAX_EDGES_DEF;
  // States at or above NUM_STATES do not exist; their bits never survive.
  localparam logic [SET_W-1:0] LIVE_MASK =
    ~({SET_W{1'b1}} << ((NUM_STATES < SET_W) ? NUM_STATES : SET_W));
  localparam int PHASE_ITEMS = 100;
  localparam int RAND_PHASES = 6;

  // One input item as it goes over the input channel.
  typedef struct packed {
    op_t                op;
    logic [STATE_W-1:0] src;
    logic [STATE_W-1:0] dst;
    logic               eps;
    logic [LABEL_W-1:0] sym;
  } nfa_item_t;

  // One result as it comes back on the result channel.
  typedef struct packed {
    logic             accepted;
    logic [SET_W-1:0] active_states;
    logic             table_full;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_operation = '0;
  logic [STATE_W-1:0]   in_edge_source = '0;
  logic [STATE_W-1:0]   in_edge_dest = '0;
  logic                 in_edge_epsilon = 1'b0;
  logic [LABEL_W-1:0]   in_symbol = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_accepted;
  logic [SET_W-1:0]     out_active_states;
  logic                 out_table_full;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  epsilon_nfa_acceptor #(
    .NUM_STATES(NUM_STATES),
    .MAX_EDGES (MAX_EDGES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_edge_source   (in_edge_source),
    .in_edge_dest     (in_edge_dest),
    .in_edge_epsilon  (in_edge_epsilon),
    .in_symbol        (in_symbol),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_active_states(out_active_states),
    .out_table_full   (out_table_full),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the edge table, active set and registers.
  // ---------------------------------------------------------------------------
  edge_t            nfa_edges [MAX_EDGES];
  int               nfa_edge_count = 0;
  logic [SET_W-1:0] nfa_active = '0;
  logic [STATE_W-1:0] reg_start_index = '0;
  logic             reg_start_present = 1'b0;
  logic [SET_W-1:0] reg_final_mask = '0;

  nfa_item_t item_backlog [$];   // items waiting for the driver
  verdict_t  verdicts_due [$];   // predicted results, oldest first
  nfa_item_t cur_item;           // item currently on the input channel

  bit in_taken = 1'b0;           // input transfer at the last rising edge
  bit out_taken = 1'b0;          // result transfer at the last rising edge
  bit quiet = 1'b0;              // no idling on either side while set
  int in_gap = 0;
  int out_wait = 0;

  int items_queued = 0;
  int n_items = 0;
  int n_results = 0;
  int n_accepts = 0;
  int n_dropped = 0;
  int n_phases = 0;
  int fail_count = 0;

  // Grow a set over epsilon edges until nothing new is reached.
  function automatic logic [SET_W-1:0] eps_closure(input logic [SET_W-1:0] seed);
    logic [SET_W-1:0] reach;
    logic [SET_W-1:0] dbit;
    logic             grew;
    reach = seed & LIVE_MASK;
    grew = 1'b1;
    while (grew) begin
      grew = 1'b0;
      for (int i = 0; i < nfa_edge_count; i++) begin
        dbit = '0;
        dbit[nfa_edges[i].dst] = 1'b1;
        dbit &= LIVE_MASK;
        if (nfa_edges[i].eps && reach[nfa_edges[i].src] && dbit != '0 &&
            (reach & dbit) == '0) begin
          reach |= dbit;
          grew = 1'b1;
        end
      end
    end
    return reach;
  endfunction

  // Follow labelled edges on one byte; epsilon edges never match, not even byte 0.
  function automatic logic [SET_W-1:0] symbol_move(input logic [SET_W-1:0] from,
                                                   input logic [LABEL_W-1:0] sym);
    logic [SET_W-1:0] next;
    next = '0;
    for (int i = 0; i < nfa_edge_count; i++) begin
      if (!nfa_edges[i].eps && nfa_edges[i].label == sym && from[nfa_edges[i].src])
        next[nfa_edges[i].dst] = 1'b1;
    end
    return next & LIVE_MASK;
  endfunction

  // Advance the predictor by one item and return the result it must produce.
  function automatic verdict_t nfa_step(input nfa_item_t it);
    verdict_t         v;
    logic [SET_W-1:0] sbit;
    v.table_full = 1'b0;
    case (it.op)
      OP_CLEAR: nfa_edge_count = 0;   // active set is left alone
      OP_ADD: begin
        if (nfa_edge_count < MAX_EDGES) begin
          nfa_edges[nfa_edge_count] = '{src: it.src, dst: it.dst, eps: it.eps,
                                        label: it.sym};
          nfa_edge_count++;
        end else begin
          v.table_full = 1'b1;
        end
      end
      OP_BEGIN: begin
        sbit = '0;
        sbit[reg_start_index] = 1'b1;
        sbit &= LIVE_MASK;
        nfa_active = (reg_start_present && sbit != '0) ? eps_closure(sbit) : '0;
      end
      default: nfa_active = eps_closure(symbol_move(nfa_active, it.sym));
    endcase
    v.accepted = reg_start_present && ((nfa_active & reg_final_mask & LIVE_MASK) != '0);
    v.active_states = nfa_active;
    return v;
  endfunction

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: present one item at a time from the backlog, hold it until
  // the transfer, then idle for the drawn gap before the next one.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (item_backlog.size() != 0) begin
        cur_item = item_backlog.pop_front();
        in_operation    <= cur_item.op;
        in_edge_source  <= cur_item.src;
        in_edge_dest    <= cur_item.dst;
        in_edge_epsilon <= cur_item.eps;
        in_symbol       <= cur_item.sym;
        in_valid        <= 1'b1;
        in_gap = draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure: after each transfer draw how long to stall the
  // next result; count the stall down only while a result is on offer.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_taken)
        out_wait = draw_wait();
      if (out_wait > 0) begin
        out_stall <= 1'b1;
        if (out_valid)
          out_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on every input transfer run the predictor, on every result
  // transfer compare against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (in_valid && !in_stall) begin
        verdicts_due.insert(verdicts_due.size(), nfa_step(cur_item));
        n_items++;
      end
      if (out_valid && !out_stall) begin
        got = '{accepted: out_accepted, active_states: out_active_states,
                table_full: out_table_full};
        n_results++;
        if (got.accepted)
          n_accepts++;
        if (got.table_full)
          n_dropped++;
        if (verdicts_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] result with nothing outstanding: accepted=%0b active=%04h full=%0b",
                     $realtime, got.accepted, got.active_states, got.table_full);
        end else begin
          want = verdicts_due.pop_front();
          if (got.accepted !== want.accepted ||
              got.active_states !== want.active_states ||
              got.table_full !== want.table_full) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"[%0t] result %0d mismatch: expected accepted=%0b active=%04h ",
                        "full=%0b, got accepted=%0b active=%04h full=%0b"},
                       $realtime, n_results, want.accepted, want.active_states,
                       want.table_full, got.accepted, got.active_states, got.table_full);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_item(input op_t op, input logic [STATE_W-1:0] src,
                            input logic [STATE_W-1:0] dst, input logic eps,
                            input logic [LABEL_W-1:0] sym);
    nfa_item_t it;
    it = '{op: op, src: src, dst: dst, eps: eps, sym: sym};
    item_backlog.insert(item_backlog.size(), it);
    items_queued++;
  endtask

  // Write one register, then mirror it into the predictor. Call only when idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_INDEX:   reg_start_index = val[STATE_W-1:0];
      CFG_START_PRESENT: reg_start_present = val[0];
      CFG_FINAL_MASK:    reg_final_mask = val[SET_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [STATE_W-1:0] start, input logic present,
                           input logic [SET_W-1:0] mask);
    write_reg(CFG_START_INDEX, CFG_DAT_W'(start));
    write_reg(CFG_START_PRESENT, CFG_DAT_W'(present));
    write_reg(CFG_FINAL_MASK, CFG_DAT_W'(mask));
    n_phases++;
    @(posedge clk);
  endtask

  // Block until every queued item has transferred and every result is back.
  task automatic wait_idle();
    while (item_backlog.size() != 0 || in_valid || verdicts_due.size() != 0)
      @(posedge clk);
  endtask

  // One scenario: mostly a well-formed automaton build followed by a string,
  // with states and labels drawn from small pools so edges actually chain.
  // A fill scenario overruns the table to provoke dropped edges.
  task automatic queue_scenario(input bit fill);
    logic [STATE_W-1:0] pool [4];
    logic [LABEL_W-1:0] alpha [3];
    int n_edges;
    int n_feeds;
    pool[0] = reg_start_index;
    for (int i = 1; i < 4; i++)
      pool[i] = STATE_W'($urandom_range(0, 15));
    for (int i = 0; i < 3; i++)
      alpha[i] = LABEL_W'($urandom);
    if ($urandom_range(0, 5) == 0)
      alpha[0] = 8'h00;
    if ($urandom_range(0, 5) == 0)
      alpha[1] = 8'hFF;
    quiet = ($urandom_range(0, 3) == 0);

    if (!fill && $urandom_range(0, 7) == 0) begin
      // noise: anything the fields allow
      repeat ($urandom_range(3, 10))
        queue_item(op_t'($urandom_range(0, 3)), STATE_W'($urandom), STATE_W'($urandom),
                   1'($urandom), LABEL_W'($urandom));
    end else begin
      if (fill || $urandom_range(0, 3) != 0)
        queue_item(OP_CLEAR, STATE_W'($urandom), STATE_W'($urandom), 1'($urandom),
                   LABEL_W'($urandom));
      n_edges = fill ? MAX_EDGES + 2 : $urandom_range(1, 10);
      repeat (n_edges)
        queue_item(OP_ADD, pool[$urandom_range(0, 3)], pool[$urandom_range(0, 3)],
                   $urandom_range(0, 2) == 0, alpha[$urandom_range(0, 2)]);
      queue_item(OP_BEGIN, '0, '0, 1'b0, LABEL_W'($urandom));
      n_feeds = $urandom_range(1, 8);
      repeat (n_feeds) begin
        case ($urandom_range(0, 15))
          0: queue_item(OP_ADD, pool[$urandom_range(0, 3)], pool[$urandom_range(0, 3)],
                        1'($urandom), alpha[$urandom_range(0, 2)]);
          1: queue_item(OP_CLEAR, '0, '0, 1'b0, '0);
          2: queue_item(OP_BEGIN, '0, '0, 1'b0, '0);
          3: queue_item(OP_FEED, '0, '0, 1'b0, LABEL_W'($urandom));
          default: queue_item(OP_FEED, '0, '0, 1'b0, alpha[$urandom_range(0, 2)]);
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int phase_mark;
    logic [STATE_W-1:0] start;
    logic               present;
    logic [SET_W-1:0]   mask;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: start state 0, finals 0 and 15.
    configure(4'd0, 1'b1, 16'h8001);
    queue_item(OP_FEED,  4'd0,  4'd0,  1'b0, 8'h00);  // feed before any begin
    queue_item(OP_BEGIN, 4'd0,  4'd0,  1'b0, 8'h00);  // empty table: just the start
    queue_item(OP_ADD,   4'd0,  4'd1,  1'b0, 8'h00);
    queue_item(OP_ADD,   4'd1,  4'd2,  1'b1, 8'h00);  // epsilon edge labelled zero
    queue_item(OP_ADD,   4'd2,  4'd15, 1'b1, 8'hFF);
    queue_item(OP_ADD,   4'd15, 4'd0,  1'b0, 8'hFF);
    queue_item(OP_ADD,   4'd0,  4'd3,  1'b1, 8'h41);
    queue_item(OP_ADD,   4'd3,  4'd3,  1'b0, 8'h80);
    queue_item(OP_BEGIN, 4'd0,  4'd0,  1'b0, 8'h00);  // closure of the start
    queue_item(OP_FEED,  4'd0,  4'd0,  1'b0, 8'h00);  // byte 0 must skip epsilon edges
    queue_item(OP_FEED,  4'd0,  4'd0,  1'b0, 8'hFF);
    queue_item(OP_FEED,  4'd0,  4'd0,  1'b0, 8'h41);  // only an epsilon label: set dies
    queue_item(OP_BEGIN, 4'd0,  4'd0,  1'b0, 8'h00);
    queue_item(OP_FEED,  4'd0,  4'd0,  1'b0, 8'h80);
    queue_item(OP_CLEAR, 4'd0,  4'd0,  1'b0, 8'h00);  // set survives the clear
    queue_item(OP_FEED,  4'd0,  4'd0,  1'b0, 8'h80);  // empty table mid-string
    queue_item(OP_ADD,   4'd15, 4'd15, 1'b1, 8'hFF);
    queue_item(OP_ADD,   4'd0,  4'd0,  1'b0, 8'h00);
    queue_item(OP_BEGIN, 4'd0,  4'd0,  1'b0, 8'h00);
    wait_idle();

    // Directed: no start state; a live set must still reject.
    configure(4'd0, 1'b0, 16'hFFFF);
    queue_item(OP_FEED,  4'd0,  4'd0,  1'b0, 8'h00);
    queue_item(OP_BEGIN, 4'd0,  4'd0,  1'b0, 8'h00);
    wait_idle();

    // Random phases: extremes first, then random settings.
    for (int p = 0; p < RAND_PHASES; p++) begin
      start   = (p == 0) ? 4'd15 : (p == 1) ? 4'd0 : STATE_W'($urandom);
      present = (p == 2) ? 1'b0 : ($urandom_range(0, 4) != 0);
      mask    = (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : SET_W'($urandom);
      configure(start, present, mask);
      phase_mark = items_queued;
      queue_scenario(p == 0);   // overrun the table once early on
      while (items_queued - phase_mark < PHASE_ITEMS)
        queue_scenario($urandom_range(0, 29) == 0);
      wait_idle();
    end

    // Let any stray result show up before judging.
    quiet = 1'b1;
    repeat (50) @(posedge clk);

    $display("Transferred %0d items and checked %0d results over %0d configuration phases",
             n_items, n_results, n_phases);
    $display("  %0d results accepting, %0d edges dropped on a full table, %0d failures",
             n_accepts, n_dropped, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard limit: far beyond the slowest legal run with full tables and maximal idling.
  initial begin
    #40ms;
    $display("Timeout with %0d results still outstanding", verdicts_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/enfa_pkg.sv
sv/epsilon_nfa_acceptor.sv
tb/testbench.sv
